// ===== src/uo_pkg.sv =====
package uo_pkg;

    localparam int SHORT_WINDOW = 7;
    localparam int MID_WINDOW   = 14;
    localparam int LONG_WINDOW  = 28;
    localparam int PRICE_WIDTH  = 32;

    localparam int MID_LONG   = (LONG_WINDOW > MID_WINDOW) ? LONG_WINDOW : MID_WINDOW;
    localparam int HIST_DEPTH = (MID_LONG > SHORT_WINDOW) ? MID_LONG : SHORT_WINDOW;

    localparam int PTR_WIDTH  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_WIDTH = $clog2(HIST_DEPTH + 1);
    localparam int IDX_WIDTH  = $clog2(2 * HIST_DEPTH);
    localparam int SUM_WIDTH  = PRICE_WIDTH + $clog2(HIST_DEPTH + 1);

    localparam int Q_BITS      = 16;
    localparam int AVG_WIDTH   = Q_BITS + 1;
    localparam int CNT_WIDTH   = $clog2(Q_BITS);
    localparam int ACC_WIDTH   = AVG_WIDTH + 2;
    localparam int WEIGHT_SUM  = 4 + 2 + 1;
    localparam int SCALE_SHIFT = ACC_WIDTH + 3;
    localparam int RECIP_WIDTH = SCALE_SHIFT - 2;
    localparam int PROD_WIDTH  = ACC_WIDTH + RECIP_WIDTH;

    localparam logic [AVG_WIDTH-1:0]   ONE_Q16 = AVG_WIDTH'(1 << Q_BITS);
    localparam logic [RECIP_WIDTH-1:0] RECIP7  =
        RECIP_WIDTH'(((1 << SCALE_SHIFT) + WEIGHT_SUM - 1) / WEIGHT_SUM);

    localparam logic [1:0] WIN_SHORT = 2'd0;
    localparam logic [1:0] WIN_MID   = 2'd1;
    localparam logic [1:0] WIN_LONG  = 2'd2;

    typedef struct packed {
        logic                   prime;
        logic [PRICE_WIDTH-1:0] pressure;
        logic [PRICE_WIDTH-1:0] range;
    } work_t;

    function automatic logic [FILL_WIDTH-1:0] window_len(input logic [1:0] win);
        logic [FILL_WIDTH-1:0] len;
        unique case (win)
            WIN_SHORT: len = FILL_WIDTH'(SHORT_WINDOW);
            WIN_MID:   len = FILL_WIDTH'(MID_WINDOW);
            WIN_LONG:  len = FILL_WIDTH'(LONG_WINDOW);
            default:   len = FILL_WIDTH'(LONG_WINDOW);
        endcase
        return len;
    endfunction

    function automatic logic [1:0] weight_shift(input logic [1:0] win);
        logic [1:0] sh;
        unique case (win)
            WIN_SHORT: sh = 2'd2;
            WIN_MID:   sh = 2'd1;
            WIN_LONG:  sh = 2'd0;
            default:   sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage

// ===== src/uo_ifs.sv =====
interface uo_bar_if;
    logic                           valid;
    logic                           ready;
    logic [uo_pkg::PRICE_WIDTH-1:0] close_price;
    logic [uo_pkg::PRICE_WIDTH-1:0] low_price;
    logic [uo_pkg::PRICE_WIDTH-1:0] high_price;

    modport source (output valid, close_price, low_price, high_price, input ready);
    modport sink   (input valid, close_price, low_price, high_price, output ready);
endinterface

interface uo_result_if;
    logic                         valid;
    logic                         ready;
    logic [uo_pkg::AVG_WIDTH-1:0] oscillator;
    logic                         value_valid;
    logic                         flat_window;

    modport source (output valid, oscillator, value_valid, flat_window, input ready);
    modport sink   (input valid, oscillator, value_valid, flat_window, output ready);
endinterface

interface uo_work_if;
    logic          valid;
    logic          ready;
    uo_pkg::work_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/uo_front.sv =====
module uo_front (
    input  logic         clk,
    input  logic         rst_n,
    uo_bar_if.sink       bar,
    uo_work_if.source    work
);

    logic [uo_pkg::PRICE_WIDTH-1:0] prev_close_reg;
    logic                           have_prev_reg;
    logic [uo_pkg::PRICE_WIDTH-1:0] floor_p;
    logic [uo_pkg::PRICE_WIDTH-1:0] ceil_p;
    logic                           accept;

    assign accept  = bar.valid && bar.ready;
    assign floor_p = (bar.low_price < prev_close_reg) ? bar.low_price : prev_close_reg;
    assign ceil_p  = (bar.high_price > prev_close_reg) ? bar.high_price : prev_close_reg;

    assign bar.ready           = work.ready;
    assign work.valid          = bar.valid;
    assign work.data.prime     = !have_prev_reg;
    assign work.data.pressure  = (bar.close_price > floor_p) ? bar.close_price - floor_p : '0;
    assign work.data.range     = ceil_p - floor_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_close_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else if (accept)
        begin
            prev_close_reg <= bar.close_price;
            have_prev_reg  <= 1'b1;
        end
    end

endmodule

// ===== src/uo_queue.sv =====
module uo_queue (
    input  logic         clk,
    input  logic         rst_n,
    uo_work_if.sink      wr,
    uo_work_if.source    rd
);

    uo_pkg::work_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign wr.ready = (count_reg != 2'd2);
    assign rd.valid = (count_reg != 2'd0);
    assign rd.data  = entry_reg[rd_ptr_reg];
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== src/uo_back.sv =====
module uo_back (
    input  logic         clk,
    input  logic         rst_n,
    uo_work_if.sink      work,
    uo_result_if.source  result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_WRITE,
        S_DIV_START,
        S_DIV,
        S_ACC,
        S_SCALE,
        S_DONE
    } state_t;

    // pressure / range history
    logic [uo_pkg::PRICE_WIDTH-1:0] hist_p [uo_pkg::HIST_DEPTH];
    logic [uo_pkg::PRICE_WIDTH-1:0] hist_r [uo_pkg::HIST_DEPTH];
    logic [uo_pkg::PRICE_WIDTH-1:0] rd_p_reg;
    logic [uo_pkg::PRICE_WIDTH-1:0] rd_r_reg;

    state_t                         state_reg;
    logic [1:0]                     win_reg;
    logic [uo_pkg::PRICE_WIDTH-1:0] bp_reg;
    logic [uo_pkg::PRICE_WIDTH-1:0] tr_reg;
    logic [uo_pkg::SUM_WIDTH-1:0]   psum_reg [3];
    logic [uo_pkg::SUM_WIDTH-1:0]   rsum_reg [3];
    logic [uo_pkg::FILL_WIDTH-1:0]  fill_reg;
    logic [uo_pkg::PTR_WIDTH-1:0]   ptr_reg;
    logic [uo_pkg::SUM_WIDTH-1:0]   rem_reg;
    logic [uo_pkg::SUM_WIDTH-1:0]   den_reg;
    logic [uo_pkg::Q_BITS-1:0]      quo_reg;
    logic [uo_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [uo_pkg::ACC_WIDTH-1:0]   acc_reg;
    logic                           flat_reg;
    logic                           full_reg;
    logic [uo_pkg::PROD_WIDTH-1:0]  prod_reg;
    logic                           out_valid_reg;
    logic [uo_pkg::AVG_WIDTH-1:0]   out_osc_reg;
    logic                           out_vv_reg;
    logic                           out_flat_reg;

    logic [uo_pkg::FILL_WIDTH-1:0]  len_w;
    logic                           drop_w;
    logic [uo_pkg::IDX_WIDTH-1:0]   idx_sum;
    logic [uo_pkg::PTR_WIDTH-1:0]   rd_addr;
    logic [uo_pkg::FILL_WIDTH-1:0]  fill_inc;
    logic [uo_pkg::SUM_WIDTH:0]     div_shift;
    logic                           div_ge;
    logic [uo_pkg::AVG_WIDTH-1:0]   avg_sel;
    logic [uo_pkg::ACC_WIDTH-1:0]   acc_add;
    logic                           out_free;
    logic                           last_win;

    assign len_w    = uo_pkg::window_len(win_reg);
    assign drop_w   = (fill_reg >= len_w);
    assign idx_sum  = uo_pkg::IDX_WIDTH'(ptr_reg) + uo_pkg::IDX_WIDTH'(uo_pkg::HIST_DEPTH)
                      - uo_pkg::IDX_WIDTH'(len_w);
    assign rd_addr  = (idx_sum >= uo_pkg::IDX_WIDTH'(uo_pkg::HIST_DEPTH))
                      ? uo_pkg::PTR_WIDTH'(idx_sum - uo_pkg::IDX_WIDTH'(uo_pkg::HIST_DEPTH))
                      : uo_pkg::PTR_WIDTH'(idx_sum);
    assign fill_inc = (fill_reg < uo_pkg::FILL_WIDTH'(uo_pkg::HIST_DEPTH))
                      ? fill_reg + 1'b1 : fill_reg;
    assign div_shift = {rem_reg, 1'b0};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign avg_sel   = (state_reg == S_ACC) ? {1'b0, quo_reg} : uo_pkg::ONE_Q16;
    assign acc_add   = acc_reg
                       + (uo_pkg::ACC_WIDTH'(avg_sel) << uo_pkg::weight_shift(win_reg));
    assign out_free  = !out_valid_reg || result.ready;
    assign last_win  = (win_reg == uo_pkg::WIN_LONG);

    assign work.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.oscillator  = out_osc_reg;
    assign result.value_valid = out_vv_reg;
    assign result.flat_window = out_flat_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            hist_p[ptr_reg] <= bp_reg;
            hist_r[ptr_reg] <= tr_reg;
        end
        rd_p_reg <= hist_p[rd_addr];
        rd_r_reg <= hist_r[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= uo_pkg::WIN_SHORT;
            bp_reg        <= '0;
            tr_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                psum_reg[i] <= '0;
                rsum_reg[i] <= '0;
            end
            fill_reg      <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            flat_reg      <= 1'b0;
            full_reg      <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_osc_reg   <= '0;
            out_vv_reg    <= 1'b0;
            out_flat_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (work.valid)
                    begin
                        bp_reg   <= work.data.pressure;
                        tr_reg   <= work.data.range;
                        win_reg  <= uo_pkg::WIN_SHORT;
                        full_reg <= 1'b0;
                        state_reg <= work.data.prime ? S_DONE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    psum_reg[win_reg] <= psum_reg[win_reg] + uo_pkg::SUM_WIDTH'(bp_reg)
                                         - (drop_w ? uo_pkg::SUM_WIDTH'(rd_p_reg) : '0);
                    rsum_reg[win_reg] <= rsum_reg[win_reg] + uo_pkg::SUM_WIDTH'(tr_reg)
                                         - (drop_w ? uo_pkg::SUM_WIDTH'(rd_r_reg) : '0);
                    if (last_win)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        win_reg   <= win_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                end
                S_WRITE:
                begin
                    ptr_reg  <= (ptr_reg == uo_pkg::PTR_WIDTH'(uo_pkg::HIST_DEPTH - 1))
                                ? '0 : ptr_reg + 1'b1;
                    fill_reg <= fill_inc;
                    win_reg  <= uo_pkg::WIN_SHORT;
                    acc_reg  <= '0;
                    flat_reg <= 1'b0;
                    if (fill_inc >= uo_pkg::FILL_WIDTH'(uo_pkg::HIST_DEPTH))
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= S_DIV_START;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIV_START:
                begin
                    priority if (rsum_reg[win_reg] == '0)
                    begin
                        flat_reg  <= 1'b1;
                        win_reg   <= win_reg + 2'd1;
                        state_reg <= last_win ? S_SCALE : S_DIV_START;
                    end
                    else if (psum_reg[win_reg] >= rsum_reg[win_reg])
                    begin
                        acc_reg   <= acc_add;
                        win_reg   <= win_reg + 2'd1;
                        state_reg <= last_win ? S_SCALE : S_DIV_START;
                    end
                    else
                    begin
                        rem_reg   <= psum_reg[win_reg];
                        den_reg   <= rsum_reg[win_reg];
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_ge ? uo_pkg::SUM_WIDTH'(div_shift - {1'b0, den_reg})
                                      : uo_pkg::SUM_WIDTH'(div_shift);
                    quo_reg <= {quo_reg[uo_pkg::Q_BITS-2:0], div_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == uo_pkg::CNT_WIDTH'(uo_pkg::Q_BITS - 1))
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    acc_reg   <= acc_add;
                    win_reg   <= win_reg + 2'd1;
                    state_reg <= last_win ? S_SCALE : S_DIV_START;
                end
                S_SCALE:
                begin
                    prod_reg  <= uo_pkg::PROD_WIDTH'(acc_reg)
                                 * uo_pkg::PROD_WIDTH'(uo_pkg::RECIP7);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_osc_reg   <= full_reg
                                         ? prod_reg[uo_pkg::SCALE_SHIFT +: uo_pkg::AVG_WIDTH]
                                         : '0;
                        out_vv_reg    <= full_reg;
                        out_flat_reg  <= full_reg && flat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= uo_pkg::FILL_WIDTH'(uo_pkg::HIST_DEPTH))
        else $error("fill count beyond history depth");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < uo_pkg::PTR_WIDTH'(uo_pkg::HIST_DEPTH))
        else $error("history pointer out of range");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_vv_reg) |-> (out_osc_reg == '0 && !out_flat_reg))
        else $error("result before full windows carries data");

    a_osc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_osc_reg <= uo_pkg::ONE_Q16))
        else $error("oscillator above 1.0");
`endif

endmodule

// ===== src/ultimate_oscillator_unit.sv =====
// Ultimate oscillator (7/14/28 bars). One item per price bar (close, low, high); every
// bar gives one result. The first bar after reset only primes the previous close and
// returns zeros, as do bars before the long window holds 28 ranges. The result is
// (4*A7 + 2*A14 + A28)/7 in unsigned Q.16 (65536 = 1.0); a window with zero range sum
// averages to 0 and sets flat_window. Once the windows are full, the three averages
// share one restoring divider of 16 steps, one bit per cycle. A 2-item queue between
// the input stage and the back end, and the output register, let input and output
// stall independently.
module ultimate_oscillator_unit (
    input  logic         clk,
    input  logic         rst_n,
    uo_bar_if.sink       bar,
    uo_result_if.source  result
);

    uo_work_if front_work ();
    uo_work_if back_work ();

    uo_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .bar   (bar),
        .work  (front_work)
    );

    uo_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_work),
        .rd    (back_work)
    );

    uo_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .work   (back_work),
        .result (result)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [uo_pkg::AVG_WIDTH-1:0] oscillator;
        logic                         value_valid;
        logic                         flat_window;
    } osc_result_t;

    localparam logic [uo_pkg::PRICE_WIDTH-1:0] PRICE_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uo_bar_if    bar_ch();
    uo_result_if result_ch();

    ultimate_oscillator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bar    (bar_ch),
        .result (result_ch)
    );

    // predictor state
    logic [uo_pkg::PRICE_WIDTH-1:0] last_close;
    bit                             primed;
    logic [uo_pkg::PRICE_WIDTH-1:0] bp_hist [uo_pkg::HIST_DEPTH];
    logic [uo_pkg::PRICE_WIDTH-1:0] tr_hist [uo_pkg::HIST_DEPTH];
    logic [63:0]                    bp_sum [3];
    logic [63:0]                    tr_sum [3];
    int unsigned                    bars_held;
    int unsigned                    slot;

    osc_result_t expected_osc [$];
    int          fail_count = 0;
    int          burst_left = 0;
    bit          quiet_sender = 1'b0;

    function automatic osc_result_t predict_oscillator(input logic [uo_pkg::PRICE_WIDTH-1:0] c,
                                                       input logic [uo_pkg::PRICE_WIDTH-1:0] l,
                                                       input logic [uo_pkg::PRICE_WIDTH-1:0] h);
        osc_result_t                    r;
        logic [uo_pkg::PRICE_WIDTH-1:0] lo_ref, hi_ref, bp, tr;
        logic [63:0]                    acc, avg;
        int unsigned                    len, idx;
        int                             w;
        r = '0;
        if (!primed)
        begin
            last_close = c;
            primed = 1'b1;
            return r;
        end
        lo_ref = (l < last_close) ? l : last_close;
        hi_ref = (h > last_close) ? h : last_close;
        bp = (c > lo_ref) ? c - lo_ref : '0;
        tr = hi_ref - lo_ref;
        last_close = c;
        for (w = 0; w < 3; w++)
        begin
            len = (w == 0) ? uo_pkg::SHORT_WINDOW
                : (w == 1) ? uo_pkg::MID_WINDOW : uo_pkg::LONG_WINDOW;
            bp_sum[w] = bp_sum[w] + 64'(bp);
            tr_sum[w] = tr_sum[w] + 64'(tr);
            if (bars_held >= len)
            begin
                idx = (slot + uo_pkg::HIST_DEPTH - len) % uo_pkg::HIST_DEPTH;
                bp_sum[w] = bp_sum[w] - 64'(bp_hist[idx]);
                tr_sum[w] = tr_sum[w] - 64'(tr_hist[idx]);
            end
        end
        bp_hist[slot] = bp;
        tr_hist[slot] = tr;
        slot = (slot + 1) % uo_pkg::HIST_DEPTH;
        if (bars_held < uo_pkg::HIST_DEPTH)
            bars_held++;
        if (bars_held >= uo_pkg::HIST_DEPTH)
        begin
            acc = '0;
            for (w = 0; w < 3; w++)
            begin
                avg = '0;
                if (tr_sum[w] == 0)
                    r.flat_window = 1'b1;
                else if (bp_sum[w] >= tr_sum[w])
                    avg = 64'(uo_pkg::ONE_Q16);
                else
                    avg = (bp_sum[w] << uo_pkg::Q_BITS) / tr_sum[w];
                acc = acc + (avg << (2 - w));
            end
            r.oscillator = uo_pkg::AVG_WIDTH'(acc / uo_pkg::WEIGHT_SUM);
            r.value_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [uo_pkg::PRICE_WIDTH-1:0] clip_price(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(PRICE_MAX))
            return PRICE_MAX;
        return uo_pkg::PRICE_WIDTH'(v);
    endfunction

    function automatic logic [uo_pkg::PRICE_WIDTH-1:0] pick_field();
        logic [uo_pkg::PRICE_WIDTH-1:0] one_hot;
        one_hot = uo_pkg::PRICE_WIDTH'(1) << $urandom_range(0, uo_pkg::PRICE_WIDTH - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PRICE_MAX;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // called right after a falling edge, returns right after a falling edge
    task automatic send_bar(input logic [uo_pkg::PRICE_WIDTH-1:0] c,
                            input logic [uo_pkg::PRICE_WIDTH-1:0] l,
                            input logic [uo_pkg::PRICE_WIDTH-1:0] h);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap != 0)
            begin
                bar_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        bar_ch.valid       = 1'b1;
        bar_ch.close_price = c;
        bar_ch.low_price   = l;
        bar_ch.high_price  = h;
        do
            @(posedge clk);
        while (!bar_ch.ready);
        expected_osc.push_back(predict_oscillator(c, l, h));
        @(negedge clk);
    endtask

    task automatic test_directed_bars();
        int n;
        send_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);   // priming bar
        send_bar('0, '0, '0);
        send_bar(PRICE_MAX, '0, PRICE_MAX);
        send_bar('0, PRICE_MAX, '0);                 // low above high
        send_bar(32'd5000, 32'd1000, 32'd2000);      // close above high
        send_bar(32'd100, 32'd3000, 32'd4000);       // close below low
        send_bar(32'd90000, 32'd80000, 32'd95000);   // gap up
        send_bar(32'd10, 32'd20, 32'd30);            // gap down
        for (n = 0; n < 8; n++)
            send_bar(32'd12345, 32'd12345, 32'd12345);
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_bar(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE);
        send_bar(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000);
        send_bar(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_bar(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'h0000_0001, 32'h0000_0000, 32'h0000_0002);
        send_bar(32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'hFFFF_FFFF);
        send_bar(32'h1234_5678, 32'h1234_0000, 32'h1235_0000);
    endtask

    task automatic test_random_walk(input int count);
        longint                         walk, span, c;
        int                             n, k;
        logic [uo_pkg::PRICE_WIDTH-1:0] close_p, low_p, high_p;
        walk = $urandom;
        span = 1;
        for (n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
            begin
                k = $urandom_range(0, 32);
                span = (longint'(1) << k) - 1;
                case ($urandom_range(0, 3))
                    0:       walk = $urandom_range(0, 1000);
                    1:       walk = longint'(PRICE_MAX) - $urandom_range(0, 1000);
                    default: walk = longint'($urandom);
                endcase
            end
            c = walk + (longint'($urandom) & span) - (longint'($urandom) & span);
            if ($urandom_range(0, 15) == 0)
                c = $urandom_range(0, 1) ? c + 8 * (span + 1) : c - 8 * (span + 1);
            close_p = clip_price(c);
            low_p   = clip_price(longint'(close_p) - (longint'($urandom) & span));
            high_p  = clip_price(longint'(close_p) + (longint'($urandom) & span));
            case ($urandom_range(0, 9))
                0:       low_p = close_p;
                1:       high_p = close_p;
                default: ;
            endcase
            walk = close_p;
            send_bar(close_p, low_p, high_p);
        end
    endtask

    task automatic test_flat_runs(input int count);
        int                             sent, run, breaks;
        logic [uo_pkg::PRICE_WIDTH-1:0] p;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 3))
                0:       p = '0;
                1:       p = PRICE_MAX;
                default: p = $urandom;
            endcase
            run = $urandom_range(1, 36);
            repeat (run) send_bar(p, p, p);
            breaks = $urandom_range(1, 4);
            repeat (breaks) send_bar(p ^ 32'h1, p, p | 32'h1);
            sent += run + breaks;
        end
    endtask

    task automatic test_noise(input int count);
        repeat (count) send_bar(pick_field(), pick_field(), pick_field());
    endtask

    // rising closes above the high: pressure exceeds range, averages saturate
    task automatic test_saturation(input int count);
        longint                         base;
        logic [uo_pkg::PRICE_WIDTH-1:0] l, h, c;
        quiet_sender = 1'b1;
        base = $urandom_range(0, 32'h3FFF_FFFF);
        repeat (count)
        begin
            base += $urandom_range(4000, 6000);
            l = clip_price(base - $urandom_range(0, 100));
            h = clip_price(longint'(l) + $urandom_range(0, 50));
            c = clip_price(base + $urandom_range(200, 4000));
            send_bar(c, l, h);
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin : result_check
        osc_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_osc.size() == 0)
                begin
                    $error("unexpected item: oscillator %0d value_valid %0b flat_window %0b",
                           result_ch.oscillator, result_ch.value_valid,
                           result_ch.flat_window);
                    fail_count++;
                end
                else
                begin
                    want = expected_osc.pop_front();
                    if (result_ch.oscillator !== want.oscillator)
                    begin
                        $error("oscillator: expected %0d, actual %0d",
                               want.oscillator, result_ch.oscillator);
                        fail_count++;
                    end
                    if (result_ch.value_valid !== want.value_valid)
                    begin
                        $error("value_valid: expected %0b, actual %0b",
                               want.value_valid, result_ch.value_valid);
                        fail_count++;
                    end
                    if (result_ch.flat_window !== want.flat_window)
                    begin
                        $error("flat_window: expected %0b, actual %0b",
                               want.flat_window, result_ch.flat_window);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : result_stall
        logic [31:0] stall_pattern;
        int          pattern_left;
        stall_pattern = '1;
        pattern_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(64, 400);
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom;
                    2:       stall_pattern = $urandom | $urandom;
                    default: stall_pattern = 32'h1 << $urandom_range(0, 31);
                endcase
            end
            result_ch.ready = stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
            pattern_left--;
        end
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        last_close = '0;
        primed = 1'b0;
        for (int i = 0; i < uo_pkg::HIST_DEPTH; i++)
        begin
            bp_hist[i] = '0;
            tr_hist[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            bp_sum[i] = '0;
            tr_sum[i] = '0;
        end
        bars_held = 0;
        slot = 0;
        rst_n = 1'b0;
        bar_ch.valid = 1'b0;
        bar_ch.close_price = '0;
        bar_ch.low_price = '0;
        bar_ch.high_price = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_bars();
        test_random_walk(1000);
        test_flat_runs(300);
        test_noise(350);
        test_saturation(175);
        bar_ch.valid = 1'b0;

        while (expected_osc.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/uo_pkg.sv
src/uo_ifs.sv
src/uo_front.sv
src/uo_queue.sv
src/uo_back.sv
src/ultimate_oscillator_unit.sv
test/testbench.sv
